[rtl/lpm_pkg.sv]
// Package for the LIKE pattern matcher: request and result words, cell kinds,
// the links between cells and the pattern compiler status.
// No dependencies; every rtl file imports it.
package lpm_pkg;

	localparam int MAX_CELLS = 64;
	localparam int CNT_W     = $clog2(MAX_CELLS + 1);

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_PERCENT    = 8'h25;
	localparam logic [7:0] CH_BACKSLASH  = 8'h5C;

	typedef enum logic [1:0] {
		REQ_APPEND  = 2'd0,
		REQ_SUBJECT = 2'd1,
		REQ_END     = 2'd2,
		REQ_CLEAR   = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		KIND_LIT = 2'd0,
		KIND_ONE = 2'd1,
		KIND_RUN = 2'd2
	} cell_kind_t;

	typedef struct packed {
		req_code_t  req_type;
		logic [7:0] data_byte;
	} req_word_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} rsp_word_t;

	// cell write from the pattern compiler
	typedef struct packed {
		logic       en;
		cell_kind_t kind;
		logic [7:0] data;
	} cell_wr_t;

	// per-word control broadcast to every cell
	typedef struct packed {
		logic       restart;
		logic       step;
		logic [7:0] sub_byte;
		logic       cont;
	} cell_ctl_t;

	// left-to-right link: raw and closed activity of one position
	typedef struct packed {
		logic act;
		logic closed;
	} cell_link_t;

	typedef struct packed {
		logic [CNT_W-1:0] cell_count;
		logic             escape_pending;
		logic             overflow_seen;
	} pat_status_t;

endpackage

[rtl/like_pattern_matcher.sv]
// SQL LIKE matcher top level: pattern compiler, chain of cells and result
// buffer. Depends on lpm_pkg, lpm_compiler, lpm_cell and lpm_out_buf.
//
//  channel | direction | handshake       | word
//  req     | in        | req_valid/stall | req_type, data_byte
//  rsp     | out       | rsp_valid/stall | matched, pattern_overflow
//
// One request word per cycle of every type while req_stall is low; each
// cell updates its active bit in parallel, so a subject byte steps all cells.
// An end-of-subject word's result reaches rsp from the buffer's head register.
// req_stall rises only while two results wait in the output buffer.
// Reset empties the pattern and leaves only position zero active; cell
// contents are unknown until written and are never read past the count.
module like_pattern_matcher import lpm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	logic                 acc;
	logic                 is_append;
	logic                 is_subject;
	logic                 is_end;
	logic                 is_clear;
	pat_status_t          status;
	cell_wr_t             wr;
	cell_ctl_t            ctl;
	logic                 a0_q;
	cell_link_t           link [MAX_CELLS+1];
	logic [MAX_CELLS:0]   run_vec;
	logic [MAX_CELLS:0]   closed_vec;
	rsp_word_t            end_word;
	logic                 buf_full;

	assign acc        = req_valid & ~req_stall;
	assign is_append  = acc & (req.req_type == REQ_APPEND);
	assign is_subject = acc & (req.req_type == REQ_SUBJECT);
	assign is_end     = acc & (req.req_type == REQ_END);
	assign is_clear   = acc & (req.req_type == REQ_CLEAR);

	lpm_compiler u_compiler (
		.clk       (clk),
		.arst_n    (arst_n),
		.append    (is_append),
		.clear     (is_clear),
		.data_byte (req.data_byte),
		.status    (status),
		.wr        (wr)
	);

	assign ctl.restart  = is_append | is_end | is_clear;
	assign ctl.step     = is_subject;
	assign ctl.sub_byte = req.data_byte;
	assign ctl.cont     = (req.data_byte[7:6] == 2'b10);

	// position zero lives outside the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a0_q <= 1'b1;
		end else if (ctl.restart) begin
			a0_q <= 1'b1;
		end else if (ctl.step) begin
			a0_q <= a0_q & run_vec[0];
		end
	end

	assign link[0].act    = a0_q;
	assign link[0].closed = a0_q;
	assign run_vec[MAX_CELLS] = 1'b0;

	genvar g;
	generate
		for (g = 0; g < MAX_CELLS; g++) begin : g_cell
			lpm_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.sel       (status.cell_count == CNT_W'(g)),
				.wr        (wr),
				.used      (CNT_W'(g) < status.cell_count),
				.ctl       (ctl),
				.left      (link[g]),
				.run_right (run_vec[g+1]),
				.right     (link[g+1]),
				.run_here  (run_vec[g])
			);
		end
		for (g = 0; g <= MAX_CELLS; g++) begin : g_closed
			assign closed_vec[g] = link[g].closed;
		end
	endgenerate

	assign end_word.matched = ~status.overflow_seen & ~status.escape_pending
		& closed_vec[status.cell_count];
	assign end_word.pattern_overflow = status.overflow_seen;

	lpm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (is_end),
		.push_word (end_word),
		.full      (buf_full),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	assign req_stall = buf_full;

`ifndef ASSERT_OFF
	a_ovf_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.pattern_overflow |-> !rsp.matched)
		else $error("result flags overflow and match together");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.cell_count <= CNT_W'(MAX_CELLS))
		else $error("cell count beyond capacity");

	a_restart_pos0: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.restart |=> a0_q)
		else $error("position zero not active after restart");

	a_stall_has_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid)
		else $error("request stalled with no result pending");

	a_empty_step: assert property (@(posedge clk) disable iff (!arst_n)
		is_subject && status.cell_count == '0 |=> !a0_q)
		else $error("empty pattern kept a position active after a byte");
`endif

endmodule

[rtl/lpm_cell.sv]
// One pattern cell: holds its kind, literal byte and the activity of the
// position just after it. Depends on lpm_pkg.
module lpm_cell import lpm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sel,
	input  cell_wr_t   wr,
	input  logic       used,
	input  cell_ctl_t  ctl,
	input  cell_link_t left,
	input  logic       run_right,
	output cell_link_t right,
	output logic       run_here
);

	cell_kind_t kind_q;
	logic [7:0] byte_q;
	logic       act_q;
	logic       is_lit;
	logic       is_one;
	logic       is_run;
	logic       nxt;

	always_ff @(posedge clk) begin
		if (sel && wr.en) begin
			kind_q <= wr.kind;
			byte_q <= wr.data;
		end
	end

	always_comb begin
		is_lit = 1'b0;
		is_one = 1'b0;
		is_run = 1'b0;
		unique case (kind_q)
			KIND_LIT: is_lit = used;
			KIND_ONE: is_one = used;
			KIND_RUN: is_run = used;
			default: ;
		endcase
	end

	// a run cell lets activity pass over it without consuming a byte
	assign right.act    = act_q;
	assign right.closed = act_q | (left.act & is_run);
	assign run_here     = is_run;

	always_comb begin
		nxt = (is_lit & left.closed & (byte_q == ctl.sub_byte))
			| (is_one & left.closed & ~ctl.cont)
			| (is_one & right.closed & ctl.cont)
			| (run_right & right.closed);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (ctl.restart) begin
			act_q <= 1'b0;
		end else if (ctl.step) begin
			act_q <= nxt;
		end
	end

endmodule

[rtl/lpm_compiler.sv]
// Pattern compiler: turns appended pattern bytes into cell writes, tracks
// escape, run collapse, cell count and overflow. Depends on lpm_pkg.
module lpm_compiler import lpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        append,
	input  logic        clear,
	input  logic [7:0]  data_byte,
	output pat_status_t status,
	output cell_wr_t    wr
);

	logic [CNT_W-1:0] count_q;
	logic             esc_q;
	logic             ovf_q;
	logic             last_run_q;
	logic             want;
	logic             set_esc;
	logic             room;
	cell_kind_t       kind;
	logic [7:0]       data;

	assign room = count_q < CNT_W'(MAX_CELLS);

	always_comb begin
		want    = 1'b0;
		set_esc = 1'b0;
		kind    = KIND_LIT;
		data    = data_byte;
		if (append) begin
			if (esc_q) begin
				want = 1'b1;
			end else begin
				case (data_byte)
					CH_BACKSLASH: set_esc = 1'b1;
					CH_PERCENT: begin
						// collapse a run that directly follows a run
						want = ~last_run_q;
						kind = KIND_RUN;
						data = 8'h00;
					end
					CH_UNDERSCORE: begin
						want = 1'b1;
						kind = KIND_ONE;
						data = 8'h00;
					end
					default: want = 1'b1;
				endcase
			end
		end
	end

	assign wr.en   = want & room;
	assign wr.kind = kind;
	assign wr.data = data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			esc_q      <= 1'b0;
			ovf_q      <= 1'b0;
			last_run_q <= 1'b0;
		end else if (clear) begin
			count_q    <= '0;
			esc_q      <= 1'b0;
			ovf_q      <= 1'b0;
			last_run_q <= 1'b0;
		end else if (append) begin
			esc_q <= set_esc;
			if (want) begin
				if (room) begin
					count_q    <= count_q + CNT_W'(1);
					last_run_q <= (kind == KIND_RUN);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	assign status.cell_count     = count_q;
	assign status.escape_pending = esc_q;
	assign status.overflow_seen  = ovf_q;

endmodule

[rtl/lpm_out_buf.sv]
// Two-entry result buffer (output register plus skid) between the matcher
// and the result channel. Depends on lpm_pkg.
module lpm_out_buf import lpm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rsp_word_t push_word,
	output logic      full,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	logic      head_v_q;
	logic      skid_v_q;
	rsp_word_t head_q;
	rsp_word_t skid_q;
	logic      pop;

	assign pop = head_v_q & ~rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= push;
			end else begin
				head_v_q <= push;
			end
		end else if (push) begin
			if (head_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				head_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= push_word;
				end
			end else if (push) begin
				head_q <= push_word;
			end
		end else if (push) begin
			if (head_v_q) begin
				skid_q <= push_word;
			end else begin
				head_q <= push_word;
			end
		end
	end

	assign full      = skid_v_q;
	assign rsp_valid = head_v_q;
	assign rsp       = head_q;

endmodule
